/* rtl/core/cwc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_pkg
// shared constants and types for the weighted coverage block
// ----------------------------------------------------------------------------
package cwc_pkg;

	localparam int MAX_TARGET_LEN_DEF = 4096;
	localparam int FRAC_BITS_DEF      = 16;

	localparam int CMD_W    = 3;
	localparam int TLEN_W   = 13;
	localparam int POS_W    = 21;
	localparam int POST_W   = 17;
	localparam int BYTE_W   = 8;
	localparam int WALK_W   = 32;
	localparam int RUN_W    = 21;
	localparam int DEPTH_W  = 48;
	localparam int COV_W    = 29;
	localparam int MEAN_W   = 40;
	localparam int IN_DW    = 80;
	localparam int OUT_DW   = 72;
	localparam int DIV_CW   = 6;

	localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic [63:0]        COVER_MAX = 64'h1FFF_FFFF;
	localparam logic [63:0]        MEAN_MAX  = 64'hFF_FFFF_FFFF;

	localparam logic [CMD_W-1:0] CMD_BEGIN_TARGET = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BEGIN_HIT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CIGAR_BYTE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SPAN_HIT     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FINISH       = 3'd4;

	localparam logic [BYTE_W-1:0] CH_M    = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_COVER,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* rtl/core/cigar_weighted_coverage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cigar_weighted_coverage
// posterior-weighted coverage and mean depth of one target, map in block ram
// ----------------------------------------------------------------------------
// The not-covered map lives in one synchronous RAM of MAX_TARGET_LEN entries.
// A begin-target item walks the target positions to write 1.0 into the map
// (no clearing pass after reset: the map is only read below the current
// length, which a begin fills first). Begin-hit, digit and non-M/D letter
// items are taken in the idle state. An M run steps through each position
// of the run (read, scale by 1-gamma, write back in the next cycle), and
// the last write-back still holds off the next item when the last position
// is on the target; a D letter is taken in the idle state, a span hit steps
// through each clipped position the same way. Finish sums the map and runs
// the bit-serial depth divide when the length is nonzero, then loads the
// output register.
// ----------------------------------------------------------------------------
module cigar_weighted_coverage #(
	parameter int MAX_TARGET_LEN = cwc_pkg::MAX_TARGET_LEN_DEF,
	parameter int FRAC_BITS      = cwc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// target_length, start_pos, end_pos, posterior, cigar_byte
	input  wire logic [cwc_pkg::IN_DW-1:0] s_tdata,
	// command
	input  wire logic [cwc_pkg::CMD_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// covered_length, mean_depth, zero pad
	output logic [cwc_pkg::OUT_DW-1:0]     m_tdata
);
	import cwc_pkg::*;

	localparam int AW  = $clog2(MAX_TARGET_LEN);
	localparam int LW  = $clog2(MAX_TARGET_LEN + 1);
	localparam int GW  = FRAC_BITS + 1;
	localparam int PW  = (POST_W > GW) ? POST_W : GW;
	localparam int CVW = AW + GW + 1;
	localparam logic [GW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// input fields
	logic [TLEN_W-1:0] in_len;
	logic [POS_W-1:0]  in_start, in_end;
	logic [POST_W-1:0] in_post;
	logic [BYTE_W-1:0] in_byte;
	logic [CMD_W-1:0]  in_cmd;
	logic              accept;

	assign in_len   = s_tdata[12:0];
	assign in_start = s_tdata[33:13];
	assign in_end   = s_tdata[54:34];
	assign in_post  = s_tdata[71:55];
	assign in_byte  = s_tdata[79:72];
	assign in_cmd   = s_tuser;

	// state
	state_t              state_q, state_d;
	logic [LW-1:0]       length_q;
	logic [WALK_W-1:0]   walk_q;
	logic [RUN_W-1:0]    run_q;
	logic [GW-1:0]       hit_gamma_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [WALK_W-1:0]   pos_q;
	logic [RUN_W-1:0]    cnt_q;
	logic [GW-1:0]       gamma_q;
	logic [LW-1:0]       idx_q;
	logic                pend_s1;
	logic [AW-1:0]       addr_s1;
	logic [GW-1:0]       keep_s1;
	logic                sum_s1;
	logic [CVW-1:0]      cov_q;
	logic [LW:0]         rem_q;
	logic [DEPTH_W-1:0]  dq_q;
	logic [DIV_CW-1:0]   dcnt_q;
	logic                out_valid_q;
	logic [COV_W-1:0]    out_cov_q;
	logic [MEAN_W-1:0]   out_mean_q;

	// map memory
	logic [GW-1:0] map_mem [MAX_TARGET_LEN];
	logic [GW-1:0] rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [GW-1:0] mem_wdata;
	logic [2*GW-1:0] prod;

	assign prod      = rd_q * keep_s1;
	assign mem_we    = (state_q == ST_FILL) || pend_s1;
	assign mem_waddr = pend_s1 ? addr_s1 : idx_q[AW-1:0];
	assign mem_wdata = pend_s1 ? prod[FRAC_BITS +: GW] : ONE;
	assign mem_raddr = (state_q == ST_SUM) ? idx_q[AW-1:0] : pos_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= map_mem[mem_raddr];
	end

	// item decode
	logic [PW-1:0]      post_w;
	logic [GW-1:0]      post_g;
	logic [LW-1:0]      len_sat;
	logic               is_digit;
	logic [24:0]        run_x10;
	logic [RUN_W-1:0]   run_n;
	logic signed [21:0] s22, e22, lo, hi, lo_c, hi_c, hi_lim;
	logic               span_ok;
	logic [RUN_W-1:0]   span_cnt;
	logic               in_range;
	logic [DEPTH_W:0]   depth_sum;
	logic [LW:0]        div_try;

	always_comb begin
		post_w   = PW'(in_post);
		post_g   = (post_w > PW'(ONE)) ? ONE : GW'(post_w);
		len_sat  = (32'(in_len) > 32'(MAX_TARGET_LEN)) ? LW'(MAX_TARGET_LEN) : LW'(in_len);
		is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		run_x10  = {1'b0, run_q, 3'b000} + {3'b000, run_q, 1'b0}
			+ 25'(in_byte - CH_ZERO);
		run_n    = (run_q == '0) ? RUN_W'(1) : run_q;
		s22      = {in_start[POS_W-1], in_start};
		e22      = {in_end[POS_W-1], in_end};
		lo       = (s22 < e22) ? s22 : e22;
		hi       = (s22 < e22) ? e22 : s22;
		hi_lim   = $signed(22'(length_q)) - 22'sd1;
		lo_c     = (lo < 22'sd0) ? 22'sd0 : lo;
		hi_c     = (hi > hi_lim) ? hi_lim : hi;
		span_ok  = hi_c >= lo_c;
		span_cnt = RUN_W'(hi_c - lo_c + 22'sd1);
		in_range = pos_q < WALK_W'(length_q);
		depth_sum = {1'b0, depth_q} + (DEPTH_W + 1)'(gamma_q);
		div_try  = {rem_q[LW-1:0], dq_q[DEPTH_W-1]};
	end

	assign s_tready = (state_q == ST_IDLE) && !pend_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_BEGIN_TARGET: if (len_sat != '0) state_d = ST_FILL;
						CMD_CIGAR_BYTE:   if (!is_digit && in_byte == CH_M) state_d = ST_COVER;
						CMD_SPAN_HIT:     if (span_ok) state_d = ST_COVER;
						CMD_FINISH:       state_d = (length_q != '0) ? ST_SUM : ST_DONE;
						default:          state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL:  if (idx_q == length_q - LW'(1)) state_d = ST_IDLE;
			ST_COVER: if (cnt_q == RUN_W'(1)) state_d = ST_IDLE;
			ST_SUM:   if (idx_q == length_q - LW'(1)) state_d = ST_DIV;
			ST_DIV:   if (dcnt_q == DIV_CW'(DEPTH_W - 1)) state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			walk_q      <= '0;
			run_q       <= '0;
			hit_gamma_q <= '0;
			depth_q     <= '0;
			pend_s1     <= 1'b0;
			sum_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			dcnt_q      <= '0;
		end else begin
			pend_s1 <= 1'b0;
			sum_s1  <= 1'b0;
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_BEGIN_TARGET: begin
								length_q    <= len_sat;
								depth_q     <= '0;
								run_q       <= '0;
								walk_q      <= '0;
								hit_gamma_q <= '0;
								idx_q       <= '0;
							end
							CMD_BEGIN_HIT: begin
								walk_q      <= {{(WALK_W - POS_W){in_start[POS_W-1]}}, in_start};
								hit_gamma_q <= post_g;
								run_q       <= '0;
							end
							CMD_CIGAR_BYTE: begin
								if (is_digit) begin
									run_q <= (run_x10 > 25'(RUN_MAX)) ? RUN_MAX : RUN_W'(run_x10);
								end else begin
									run_q <= '0;
									if (in_byte == CH_M) begin
										pos_q   <= walk_q;
										cnt_q   <= run_n;
										gamma_q <= hit_gamma_q;
										walk_q  <= walk_q + WALK_W'(run_n);
									end else if (in_byte == CH_D) begin
										walk_q <= walk_q + WALK_W'(run_n);
									end
								end
							end
							CMD_SPAN_HIT: begin
								pos_q   <= WALK_W'(lo_c);
								cnt_q   <= span_cnt;
								gamma_q <= post_g;
							end
							CMD_FINISH: begin
								idx_q <= '0;
								cov_q <= '0;
								dq_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_FILL: idx_q <= idx_q + LW'(1);
				ST_COVER: begin
					// read now, scaled write-back lands in the next cycle
					pend_s1 <= in_range;
					addr_s1 <= pos_q[AW-1:0];
					keep_s1 <= ONE - gamma_q;
					if (in_range) begin
						depth_q <= depth_sum[DEPTH_W] ? DEPTH_MAX : depth_sum[DEPTH_W-1:0];
					end
					pos_q <= pos_q + WALK_W'(1);
					cnt_q <= cnt_q - RUN_W'(1);
				end
				ST_SUM: begin
					sum_s1 <= 1'b1;
					idx_q  <= idx_q + LW'(1);
					if (idx_q == length_q - LW'(1)) begin
						rem_q  <= '0;
						dq_q   <= depth_q;
						dcnt_q <= '0;
					end
				end
				ST_DIV: begin
					// restoring divide, one quotient bit a cycle
					dcnt_q <= dcnt_q + DIV_CW'(1);
					if (div_try >= {1'b0, length_q}) begin
						rem_q <= div_try - {1'b0, length_q};
						dq_q  <= {dq_q[DEPTH_W-2:0], 1'b1};
					end else begin
						rem_q <= div_try;
						dq_q  <= {dq_q[DEPTH_W-2:0], 1'b0};
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_cov_q   <= (64'(cov_q) > COVER_MAX) ? COV_W'(COVER_MAX) : COV_W'(cov_q);
						out_mean_q  <= (64'(dq_q) > MEAN_MAX) ? MEAN_W'(MEAN_MAX) : MEAN_W'(dq_q);
					end
				end
				default: ;
			endcase
			if (sum_s1) begin
				cov_q <= cov_q + CVW'(ONE - rd_q);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_mean_q, out_cov_q};

`ifndef SYNTHESIS
	a_no_accept_during_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !s_tready)
		else $error("item taken while a map write-back is pending");

	a_writeback_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (LW'(addr_s1) < length_q))
		else $error("map write-back outside the target");

	a_fill_no_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> !pend_s1)
		else $error("fill overlaps a cover write-back");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the finish sequence");
`endif

endmodule
`default_nettype wire

/* test/cigar_weighted_coverage_test.sv */
// ----------------------------------------------------------------------------
// cigar_weighted_coverage_test
// self-checking bench for the posterior-weighted target coverage block
// ----------------------------------------------------------------------------
// Commands go in on the slave stream and finish results are checked on the
// master stream. A behavioral copy of the coverage map, walk position, run
// count and depth sum predicts each result. Directed cases come first, then
// random targets with well-formed hits mixed with noise, under random gaps
// and back-pressure.
// ----------------------------------------------------------------------------
module cigar_weighted_coverage_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cwc_pkg::*;

	localparam int MAP_LEN    = 4096;
	localparam int ONE        = 65536;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [TLEN_W-1:0] tlen;
		logic [POS_W-1:0]  spos;
		logic [POS_W-1:0]  epos;
		logic [POST_W-1:0] post;
		logic [BYTE_W-1:0] ch;
	} cov_cmd_t;

	typedef struct {
		logic [COV_W-1:0]  covered;
		logic [MEAN_W-1:0] mean;
	} cov_sum_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata = '0;
	logic [CMD_W-1:0]    s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_DW-1:0]   m_tdata;

	// shadow state of the block
	logic [POST_W-1:0]   shadow_map [MAP_LEN];
	logic [TLEN_W-1:0]   shadow_len;
	logic [WALK_W-1:0]   shadow_walk;
	logic [RUN_W-1:0]    shadow_run;
	logic [POST_W-1:0]   shadow_gamma;
	logic [DEPTH_W-1:0]  shadow_depth;

	cov_sum_t            pending_sums[$];
	int                  mismatches = 0;
	int                  items_sent = 0;
	int                  sums_seen = 0;
	int                  idle_cycles = 0;
	bit                  no_gaps = 1'b0;
	int                  ready_pct = 100;

	cigar_weighted_coverage i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [POST_W-1:0] sat_gamma(logic [POST_W-1:0] g);
		return (g > ONE) ? POST_W'(ONE) : g;
	endfunction

	function automatic void cover_pos(logic [WALK_W-1:0] pos, logic [POST_W-1:0] g);
		logic [63:0] prod;
		logic [63:0] dsum;
		if (pos >= shadow_len || pos >= MAP_LEN)
			return;
		prod = (64'(shadow_map[pos]) * 64'(ONE - g)) >> 16;
		shadow_map[pos] = POST_W'(prod);
		dsum = 64'(shadow_depth) + 64'(g);
		shadow_depth = (dsum > 64'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(dsum);
	endfunction

	function automatic void clear_shadow();
		foreach (shadow_map[i])
			shadow_map[i] = POST_W'(ONE);
		shadow_len = '0;
		shadow_walk = '0;
		shadow_run = '0;
		shadow_gamma = '0;
		shadow_depth = '0;
	endfunction

	// update the shadow state for one accepted item, queue a sum on finish
	function automatic void predict_coverage(cov_cmd_t c);
		logic [63:0] r;
		logic [WALK_W-1:0] n;
		longint lo;
		longint hi;
		logic [63:0] cov;
		logic [63:0] mean;
		cov_sum_t s;
		case (c.cmd)
			CMD_BEGIN_TARGET: begin
				clear_shadow();
				shadow_len = (c.tlen > MAP_LEN) ? TLEN_W'(MAP_LEN) : c.tlen;
			end
			CMD_BEGIN_HIT: begin
				shadow_walk = WALK_W'(signed'(c.spos));
				shadow_gamma = sat_gamma(c.post);
				shadow_run = '0;
			end
			CMD_CIGAR_BYTE: begin
				if (c.ch >= CH_ZERO && c.ch <= CH_NINE) begin
					r = 64'(shadow_run) * 10 + 64'(c.ch - CH_ZERO);
					shadow_run = (r > 64'(RUN_MAX)) ? RUN_MAX : RUN_W'(r);
				end else begin
					n = (shadow_run == 0) ? 1 : WALK_W'(shadow_run);
					shadow_run = '0;
					if (c.ch == CH_M) begin
						for (int k = 0; k < n; k++) begin
							cover_pos(shadow_walk, shadow_gamma);
							shadow_walk += 1;
						end
					end else if (c.ch == CH_D) begin
						shadow_walk += n;
					end
				end
			end
			CMD_SPAN_HIT: begin
				lo = longint'(signed'(c.spos));
				hi = longint'(signed'(c.epos));
				if (lo > hi) begin
					lo = hi;
					hi = longint'(signed'(c.spos));
				end
				if (lo < 0)
					lo = 0;
				if (hi > longint'(shadow_len) - 1)
					hi = longint'(shadow_len) - 1;
				for (longint p = lo; p <= hi; p++)
					cover_pos(WALK_W'(p), sat_gamma(c.post));
			end
			CMD_FINISH: begin
				cov = 0;
				mean = 0;
				if (shadow_len != 0) begin
					for (int p = 0; p < shadow_len; p++)
						cov += 64'(ONE - shadow_map[p]);
					mean = 64'(shadow_depth) / 64'(shadow_len);
				end
				s.covered = (cov > COVER_MAX) ? COV_W'(COVER_MAX) : COV_W'(cov);
				s.mean = (mean > MEAN_MAX) ? MEAN_W'(MEAN_MAX) : MEAN_W'(mean);
				pending_sums = {pending_sums, s};
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// drive one item, wait for acceptance, then maybe idle
	task automatic send_item(cov_cmd_t c);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= c.cmd;
		s_tdata <= {c.ch, c.post, c.epos, c.spos, c.tlen};
		do
			@(posedge clk);
		while (!s_tready);
		predict_coverage(c);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic cov_cmd_t make_cmd(logic [CMD_W-1:0] cmd, int tlen = 0,
			int spos = 0, int epos = 0, int post = 0, int ch = 0);
		cov_cmd_t c;
		c.cmd = cmd;
		c.tlen = TLEN_W'(tlen);
		c.spos = POS_W'(spos);
		c.epos = POS_W'(epos);
		c.post = POST_W'(post);
		c.ch = BYTE_W'(ch);
		return c;
	endfunction

	task automatic send_cigar(string text);
		for (int i = 0; i < text.len(); i++)
			send_item(make_cmd(CMD_CIGAR_BYTE, 0, 0, 0, 0, text[i]));
	endtask

	task automatic test_directed();
		// bytes and finish before any begin act on the reset state
		send_cigar("M");
		send_item(make_cmd(CMD_FINISH));
		send_item(make_cmd(CMD_BEGIN_TARGET, 0));
		send_item(make_cmd(5));
		send_item(make_cmd(6, 8191, -1, -1, 131071, 255));
		send_item(make_cmd(7));
		send_item(make_cmd(CMD_FINISH));
		// oversized length, reversed full-range span with gamma above one
		send_item(make_cmd(CMD_BEGIN_TARGET, 8191));
		send_item(make_cmd(CMD_SPAN_HIT, 0, 1048575, -1048576, 131071));
		send_item(make_cmd(CMD_FINISH));
		send_item(make_cmd(CMD_BEGIN_TARGET, 10));
		send_item(make_cmd(CMD_BEGIN_HIT, 0, -3, 0, 40000));
		// negative start, missing count, delete, other letter, long count
		send_cigar("5MM2D3XM9999999D");
		send_item(make_cmd(CMD_SPAN_HIT, 0, 8, 3, 0));
		send_item(make_cmd(CMD_FINISH));
	endtask

	task automatic send_noise();
		cov_cmd_t c;
		c.cmd = CMD_W'($urandom);
		c.tlen = TLEN_W'($urandom);
		c.spos = POS_W'($urandom);
		c.epos = POS_W'($urandom);
		c.post = POST_W'($urandom);
		c.ch = BYTE_W'($urandom);
		// keep match runs short enough for the run time
		if (c.cmd == CMD_CIGAR_BYTE && c.ch == CH_M && shadow_run > 1000)
			c.ch = CH_D;
		send_item(c);
	endtask

	task automatic send_random_hit();
		int len;
		int g;
		int ops;
		int cnt;
		int op;
		len = shadow_len;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, ONE);
		if ($urandom_range(0, 3) == 0) begin
			send_item(make_cmd(CMD_SPAN_HIT, 0, $urandom_range(0, len + 8) - 4,
				$urandom_range(0, len + 8) - 4, g));
			return;
		end
		send_item(make_cmd(CMD_BEGIN_HIT, 0, $urandom_range(0, len + 8) - 6, 0, g));
		ops = $urandom_range(1, 6);
		for (int i = 0; i < ops; i++) begin
			cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 12);
			if (cnt > 0)
				send_cigar($sformatf("%0d", cnt));
			op = $urandom_range(0, 3);
			if (op < 2)
				send_cigar("M");
			else if (op == 2)
				send_cigar("D");
			else begin
				do
					op = $urandom_range(0, 255);
				while (op >= CH_ZERO && op <= CH_NINE);
				send_item(make_cmd(CMD_CIGAR_BYTE, 0, 0, 0, 0, op));
			end
		end
	endtask

	task automatic test_random_targets(int count);
		int stop;
		int len;
		stop = items_sent + count;
		while (items_sent < stop) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 64);
			send_item(make_cmd(CMD_BEGIN_TARGET, len));
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_random_hit();
			end
			send_item(make_cmd(CMD_FINISH));
		end
		no_gaps = 1'b0;
	endtask

	// sender holds off until every sum is back
	task automatic test_drain_pause();
		send_item(make_cmd(CMD_BEGIN_TARGET, 20));
		send_item(make_cmd(CMD_SPAN_HIT, 0, 2, 11, 30000));
		send_item(make_cmd(CMD_FINISH));
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		send_item(make_cmd(CMD_FINISH));
	endtask

	// result check and random back-pressure
	always @(posedge clk) begin
		cov_sum_t want;
		logic [COV_W-1:0] got_cov;
		logic [MEAN_W-1:0] got_mean;
		if (arst_n && m_tvalid && m_tready) begin
			got_cov = m_tdata[COV_W-1:0];
			got_mean = m_tdata[COV_W+MEAN_W-1:COV_W];
			sums_seen++;
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result cov=%0d mean=%0d", got_cov, got_mean);
			end else begin
				want = pending_sums.pop_front();
				if (got_cov !== want.covered || got_mean !== want.mean) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: cov exp %0d got %0d, mean exp %0d got %0d",
							sums_seen, want.covered, got_cov, want.mean, got_mean);
				end
			end
		end
		if ($urandom_range(0, 299) == 0)
			ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
		m_tready <= ($urandom_range(0, 99) < ready_pct);
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("cigar_weighted_coverage_test: FAIL");
			$finish;
		end
	end

	initial begin
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_targets(900);
		test_drain_pause();
		test_random_targets(900);
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d items over directed and random targets, checked %0d results",
			items_sent, sums_seen);
		if (mismatches == 0 && pending_sums.size() == 0) begin
			$display("cigar_weighted_coverage_test: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("cigar_weighted_coverage_test: FAIL");
		end
		$finish;
	end

endmodule

/* cigar_weighted_coverage.f */
rtl/core/cwc_pkg.sv
rtl/core/cigar_weighted_coverage.sv
test/cigar_weighted_coverage_test.sv
